@@ src/trs_pkg.sv @@
// trs_pkg: types and constants for the test rig sequencer.
// No dependencies; imported by test_rig_sequencer_unit.
`timescale 1ns / 1ps

package trs_pkg;

   // Field widths fixed by the interface
   localparam int TempWidth    = 14;
   localparam int LoopsWidth   = 24;
   localparam int PulseWidth   = 16;
   localparam int CdWidth      = 4;
   localparam int CsrIdxWidth  = 3;
   localparam int CsrDataWidth = 24;

   localparam int CountWidthDefault = 24;

   // Register indexes
   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_HEAT_TARGET       = 3'd0,
      CSR_LOOP_GOAL         = 3'd1,
      CSR_PULSE_MIN_US      = 3'd2,
      CSR_PULSE_MAX_US      = 3'd3,
      CSR_COUNTDOWN_SECONDS = 3'd4
   } csr_index_type;

   // Register reset values
   localparam logic signed [TempWidth-1:0] TempSetpointReset = 14'sd900;
   localparam logic [LoopsWidth-1:0]       TotalLoopsReset   = 24'd30;
   localparam logic [PulseWidth-1:0]       PulseMinReset     = 16'd990;
   localparam logic [PulseWidth-1:0]       PulseMaxReset     = 16'd1010;
   localparam logic [CdWidth-1:0]          CountdownReset    = 4'd10;

   typedef enum logic [2:0] {
      PH_STANDBY = 3'd0,
      PH_HEATING = 3'd1,
      PH_RUNNING = 3'd2,
      PH_PAUSED  = 3'd3,
      PH_DONE    = 3'd4,
      PH_RESET   = 3'd5
   } phase_type;

   // Command flags of one result word
   typedef struct packed {
      logic heaters_off;
      logic heaters_arm;
      logic heater_regulate;
      logic program_stop;
      logic read_torque;
      logic reset_test;
      logic done_light;
   } cmd_type;

endpackage

@@ src/test_rig_sequencer_unit.sv @@
// test_rig_sequencer_unit: six-phase sequencer for a heated cyclic test rig.
// Depends on trs_pkg (phase type, register indexes, reset values).
`timescale 1ns / 1ps

// One request word is one poll of the control loop; every poll gives exactly
// one response word, registered, in the cycle after the request is taken. A new
// poll is accepted every cycle as long as the response register is empty or
// being drained in the same cycle, so the sustained rate is one word per
// clock. Within a poll a finished loop pulse whose width lies in
// [pulse_min_us, pulse_max_us) bumps the saturating loop count, a torque edge
// latches a torque request, then the phase machine (standby, heating,
// running, paused, completed, reset) steps once. Holding reset in the reset
// phase counts down countdown_seconds ticks; on expiry the loop count clears,
// reset_test pulses and the countdown reloads. Registers are written through
// the csr_ port (index 0 heating target, 1 loop goal, 2 pulse_min_us,
// 3 pulse_max_us, 4 countdown_seconds) and should only change while idle.
// COUNT_WIDTH sets the internal loop counter; rsp_loops_done shows its low
// 24 bits.

module test_rig_sequencer_unit #(
   parameter int COUNT_WIDTH = trs_pkg::CountWidthDefault
) (
   input  logic                                    clock,
   input  logic                                    reset,

   input  logic                                    csr_we,
   input  logic [trs_pkg::CsrIdxWidth-1:0]         csr_index,
   input  logic [trs_pkg::CsrDataWidth-1:0]        csr_wdata,

   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_run_switch,
   input  logic                                    req_reset_switch,
   input  logic signed [trs_pkg::TempWidth-1:0]    req_sump_temp,
   input  logic                                    req_second_tick,
   input  logic                                    req_torque_edge,
   input  logic                                    req_pulse_done,
   input  logic [trs_pkg::PulseWidth-1:0]          req_pulse_width_us,

   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [2:0]                              rsp_phase,
   output logic                                    rsp_heaters_off,
   output logic                                    rsp_heaters_arm,
   output logic                                    rsp_heater_regulate,
   output logic                                    rsp_program_stop,
   output logic                                    rsp_read_torque,
   output logic                                    rsp_reset_test,
   output logic                                    rsp_done_light,
   output logic [trs_pkg::LoopsWidth-1:0]          rsp_loops_done,
   output logic [trs_pkg::CdWidth-1:0]             rsp_countdown_left
);

   import trs_pkg::*;

   // Compare width covers both the counter and total_loops
   localparam int CmpWidth = (COUNT_WIDTH > LoopsWidth) ? COUNT_WIDTH : LoopsWidth;

   // ---- configuration registers
   logic signed [TempWidth-1:0] setpoint_ff;
   logic [LoopsWidth-1:0]       total_loops_ff;
   logic [PulseWidth-1:0]       pulse_min_ff;
   logic [PulseWidth-1:0]       pulse_max_ff;
   logic [CdWidth-1:0]          cd_seconds_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff    <= TempSetpointReset;
         total_loops_ff <= TotalLoopsReset;
         pulse_min_ff   <= PulseMinReset;
         pulse_max_ff   <= PulseMaxReset;
         cd_seconds_ff  <= CountdownReset;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_HEAT_TARGET:       setpoint_ff    <= csr_wdata[TempWidth-1:0];
            CSR_LOOP_GOAL:         total_loops_ff <= csr_wdata[LoopsWidth-1:0];
            CSR_PULSE_MIN_US:      pulse_min_ff   <= csr_wdata[PulseWidth-1:0];
            CSR_PULSE_MAX_US:      pulse_max_ff   <= csr_wdata[PulseWidth-1:0];
            CSR_COUNTDOWN_SECONDS: cd_seconds_ff  <= csr_wdata[CdWidth-1:0];
            default: ;  // unmapped index, ignored
         endcase
      end
   end

   // ---- sequencer state
   phase_type              phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   torque_ff, torque_in;
   logic [CdWidth-1:0]     cd_ff, cd_in;

   // ---- response register
   logic                   rsp_valid_ff;
   phase_type              rsp_phase_ff;
   cmd_type                rsp_cmd_ff, cmd;
   logic [LoopsWidth-1:0]  rsp_loops_ff;
   logic [CdWidth-1:0]     rsp_cd_ff;

   logic accept;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // ---- event intake: pulse qualification and torque latch
   logic                   pulse_ok;
   logic [COUNT_WIDTH-1:0] count_pulse;
   logic                   torque_pend;
   logic                   reached;
   logic                   cd_expired;
   logic [CmpWidth-1:0]    count_ext;

   assign pulse_ok = req_pulse_done
                  && (req_pulse_width_us >= pulse_min_ff)
                  && (req_pulse_width_us <  pulse_max_ff)
                  && (count_ff != {COUNT_WIDTH{1'b1}});  // saturate

   assign count_pulse = pulse_ok ? count_ff + COUNT_WIDTH'(1) : count_ff;
   assign torque_pend = torque_ff | req_torque_edge;
   assign reached     = CmpWidth'(count_pulse) >= CmpWidth'(total_loops_ff);
   // zero seconds left behaves as one
   assign cd_expired  = (cd_ff <= CdWidth'(1));

   // ---- next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_HEATING: begin
            if (req_sump_temp >= setpoint_ff) begin
               phase_in = req_run_switch ? PH_RUNNING : PH_STANDBY;
            end
         end
         PH_RUNNING: begin
            // a released run switch wins over completion
            if (!req_run_switch)  phase_in = PH_PAUSED;
            else if (reached)     phase_in = PH_DONE;
         end
         PH_PAUSED: begin
            if (req_run_switch)        phase_in = PH_HEATING;
            else if (req_reset_switch) phase_in = PH_RESET;
         end
         PH_DONE: begin
            if (req_reset_switch) phase_in = PH_RESET;
         end
         PH_RESET: begin
            if (!req_reset_switch) phase_in = reached ? PH_DONE : PH_STANDBY;
         end
         default: begin
            if (req_run_switch)        phase_in = PH_HEATING;
            else if (req_reset_switch) phase_in = PH_RESET;
         end
      endcase
   end

   // ---- commands and datapath updates
   always_comb begin
      cmd       = '0;
      count_in  = count_pulse;
      torque_in = torque_pend;
      cd_in     = cd_ff;
      unique case (phase_ff)
         PH_HEATING: begin
            if (req_sump_temp < setpoint_ff) begin
               cmd.program_stop    = 1'b1;
               cmd.heaters_arm     = 1'b1;
               cmd.heater_regulate = 1'b1;
            end
         end
         PH_RUNNING: begin
            cmd.read_torque     = torque_pend;
            torque_in           = 1'b0;
            cmd.heater_regulate = 1'b1;
         end
         PH_PAUSED: begin
            cmd.program_stop = 1'b1;
            cmd.heaters_off  = 1'b1;
         end
         PH_DONE: begin
            cmd.done_light   = 1'b1;
            cmd.heaters_off  = 1'b1;
            cmd.program_stop = 1'b1;
         end
         PH_RESET: begin
            if (!req_reset_switch) begin
               cd_in          = '0;  // released: countdown aborted
               cmd.done_light = reached;
            end else begin
               cmd.heaters_off  = 1'b1;
               cmd.program_stop = 1'b1;
               if (req_second_tick) begin
                  if (cd_expired) begin
                     // test reset overrides a pulse of the same poll
                     count_in       = '0;
                     cmd.reset_test = 1'b1;
                     cd_in          = cd_seconds_ff;
                  end else begin
                     cd_in = cd_ff - CdWidth'(1);
                  end
               end
            end
         end
         default: begin
            if (!req_run_switch && !req_reset_switch) cmd.heaters_off = 1'b1;
         end
      endcase
      // entering reset loads the countdown
      if (phase_in == PH_RESET && phase_ff != PH_RESET) cd_in = cd_seconds_ff;
   end

   assign count_ext = CmpWidth'(count_in);

   // ---- state update, one poll per accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_STANDBY;
         count_ff  <= '0;
         torque_ff <= 1'b0;
         cd_ff     <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         torque_ff <= torque_in;
         cd_ff     <= cd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_phase_ff <= phase_in;
         rsp_cmd_ff   <= cmd;
         rsp_loops_ff <= count_ext[LoopsWidth-1:0];
         rsp_cd_ff    <= (phase_in == PH_RESET) ? cd_in : '0;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_phase           = rsp_phase_ff;
   assign rsp_heaters_off     = rsp_cmd_ff.heaters_off;
   assign rsp_heaters_arm     = rsp_cmd_ff.heaters_arm;
   assign rsp_heater_regulate = rsp_cmd_ff.heater_regulate;
   assign rsp_program_stop    = rsp_cmd_ff.program_stop;
   assign rsp_read_torque     = rsp_cmd_ff.read_torque;
   assign rsp_reset_test      = rsp_cmd_ff.reset_test;
   assign rsp_done_light      = rsp_cmd_ff.done_light;
   assign rsp_loops_done      = rsp_loops_ff;
   assign rsp_countdown_left  = rsp_cd_ff;

endmodule
